FILE: rtl/sfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, codes and the CRC-16 step for the serial frame checker.
// ----------------------------------------------------------------------------
package sfc_pkg;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_LENGTH = 2'd1,
        ERR_CRC    = 2'd2,
        ERR_SYNC   = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAYLOAD,
        ST_ACK,
        ST_ERROR
    } state_t;

    // Control strobes from the sequencer to the frame store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    localparam int MIN_FRAME     = 5;
    localparam int PAYLOAD_START = 2;   // length byte and sequence byte come first
    localparam int TAIL_LEN      = 3;   // CRC high, CRC low, sync byte

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  SYNC_RESET = 8'h7E;
    localparam logic [7:0]  SEQ_MASK   = 8'h0F;
    localparam logic [7:0]  ACK_MARK   = 8'h10;
    localparam logic [7:0]  ACK_LEN    = 8'd5;

    // Positions of the bytes within the acknowledge frame.
    localparam int ACK_POS_LEN    = 0;
    localparam int ACK_POS_SEQ    = 1;
    localparam int ACK_POS_CRC_HI = 2;
    localparam int ACK_POS_CRC_LO = 3;
    localparam int ACK_POS_SYNC   = 4;

    // One byte of the reflected CCITT CRC (polynomial 0x8408).
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0] b;
        b = data ^ crc[7:0];
        b = b ^ {b[3:0], 4'b0000};
        return {b, crc[15:8]} ^ {12'b0, b[7:4]} ^ {5'b0, b, 3'b000};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sfc_frame_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_frame_mem
// Frame store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfc_frame_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic              clk,
    input  wire sfc_pkg::mem_ctl_t ctl,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic [AW-1:0]     raddr,
    output logic [7:0]             rdata
);
    import sfc_pkg::*;

    logic [7:0] frame_ram [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            frame_ram[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= frame_ram[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/sfc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_ctrl
// Framing sequencer: tracks position, length and CRC, writes bytes to the
// frame store, and reads the payload back out followed by the acknowledge, or gives an error result.
// ----------------------------------------------------------------------------
module sfc_ctrl #(
    parameter int MAX_FRAME = 64,
    parameter int AW        = 6,
    parameter int LW        = 7
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [7:0]        sync_value,
    output sfc_pkg::mem_ctl_t      mem_ctl,
    output logic [AW-1:0]          mem_waddr,
    output logic [7:0]             mem_wdata,
    output logic [AW-1:0]          mem_raddr,
    input  wire logic [7:0]        mem_rdata,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             out_kind,
    output logic [7:0]             out_data,
    output logic [1:0]             error_code,
    output logic                   last
);
    import sfc_pkg::*;

    localparam int CW = LW + 1;

    state_t         state_reg, state_next;
    logic           hunting_reg, hunting_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [15:0]    crc_reg, crc_next;
    logic [7:0]     b1_reg, b1_next;
    logic [7:0]     b2_reg, b2_next;
    logic [7:0]     seq_reg, seq_next;
    logic [AW-1:0]  idx_reg, idx_next;
    err_t           err_reg, err_next;

    logic           out_valid_reg, out_valid_next;
    kind_t          out_kind_reg, out_kind_next;
    logic [7:0]     out_data_reg, out_data_next;
    err_t           out_err_reg, out_err_next;
    logic           out_last_reg, out_last_next;

    logic           accept;
    logic           out_free;
    logic [LW-1:0]  len_eff;
    logic [CW-1:0]  pos_ext;
    logic [CW-1:0]  len_ext;
    logic           bad_len;
    logic           complete;
    logic           fail;
    err_t           fail_code;
    logic [7:0]     ack_seq;
    logic [15:0]    ack_crc;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign ack_seq = ((seq_reg + 8'd1) & SEQ_MASK) | ACK_MARK;
    assign ack_crc = crc_feed(crc_feed(CRC_INIT, ACK_LEN), ack_seq);

    assign bad_len  = (rx_byte < 8'(MIN_FRAME)) || (9'(rx_byte) > 9'(MAX_FRAME));
    assign len_eff  = (pos_reg == '0) ? rx_byte[LW-1:0] : len_reg;
    assign pos_ext  = CW'(pos_reg);
    assign len_ext  = CW'(len_eff);
    assign complete = (pos_ext + CW'(1) == len_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hunting_reg   <= 1'b0;
            pos_reg       <= '0;
            len_reg       <= '0;
            crc_reg       <= CRC_INIT;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hunting_reg   <= hunting_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        seq_reg      <= seq_next;
        err_reg      <= err_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        hunting_next   = hunting_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        seq_next       = seq_reg;
        idx_next       = idx_reg;
        err_next       = err_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_ctl        = '0;
        mem_waddr      = pos_reg;
        mem_wdata      = rx_byte;
        mem_raddr      = AW'(PAYLOAD_START);
        fail           = 1'b0;
        fail_code      = ERR_NONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (hunting_reg)
                    begin
                        if (rx_byte == sync_value)
                        begin
                            hunting_next = 1'b0;
                        end
                    end
                    else if ((pos_reg == '0) && bad_len)
                    begin
                        fail      = 1'b1;
                        fail_code = ERR_LENGTH;
                    end
                    else
                    begin
                        mem_ctl.wr_en = 1'b1;
                        len_next      = len_eff;
                        b1_next       = rx_byte;
                        b2_next       = b1_reg;
                        pos_next      = pos_reg + AW'(1);
                        if (pos_reg == AW'(1))
                        begin
                            seq_next = rx_byte;
                        end
                        if (pos_ext + CW'(TAIL_LEN) < len_ext)
                        begin
                            crc_next = crc_feed(crc_reg, rx_byte);
                        end
                        if (complete)
                        begin
                            // The CRC field is never fed, so crc_reg is final here.
                            if (rx_byte != sync_value)
                            begin
                                fail      = 1'b1;
                                fail_code = ERR_SYNC;
                            end
                            else if ({b2_reg, b1_reg} != crc_reg)
                            begin
                                fail      = 1'b1;
                                fail_code = ERR_CRC;
                            end
                            else
                            begin
                                pos_next = '0;
                                crc_next = CRC_INIT;
                                if (len_ext > CW'(MIN_FRAME))
                                begin
                                    mem_ctl.rd_en = 1'b1;
                                    mem_raddr     = AW'(PAYLOAD_START);
                                    idx_next      = AW'(PAYLOAD_START);
                                    state_next    = ST_PAYLOAD;
                                end
                                else
                                begin
                                    idx_next   = '0;
                                    state_next = ST_ACK;
                                end
                            end
                        end
                    end

                    if (fail)
                    begin
                        pos_next     = '0;
                        crc_next     = CRC_INIT;
                        hunting_next = (rx_byte != sync_value);
                        err_next     = fail_code;
                        state_next   = ST_ERROR;
                    end
                end
            end

            ST_PAYLOAD:
            begin
                // Read data for idx_reg is always registered and held until the next read.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_PAYLOAD;
                    out_data_next  = mem_rdata;
                    out_err_next   = ERR_NONE;
                    out_last_next  = 1'b0;
                    if (CW'(idx_reg) + CW'(1 + TAIL_LEN) < CW'(len_reg))
                    begin
                        mem_ctl.rd_en = 1'b1;
                        mem_raddr     = idx_reg + AW'(1);
                        idx_next      = idx_reg + AW'(1);
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_ACK;
                    end
                end
            end

            ST_ACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ACK;
                    out_err_next   = ERR_NONE;
                    out_last_next  = 1'b0;
                    idx_next       = idx_reg + AW'(1);
                    case (idx_reg)
                        AW'(ACK_POS_LEN):    out_data_next = ACK_LEN;
                        AW'(ACK_POS_SEQ):    out_data_next = ack_seq;
                        AW'(ACK_POS_CRC_HI): out_data_next = ack_crc[15:8];
                        AW'(ACK_POS_CRC_LO): out_data_next = ack_crc[7:0];
                        default:
                        begin
                            out_data_next = sync_value;
                            out_last_next = 1'b1;
                            idx_next      = '0;
                            state_next    = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ERROR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ERROR;
                    out_data_next  = 8'd0;
                    out_err_next   = err_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_data   = out_data_reg;
    assign error_code = out_err_reg;
    assign last       = out_last_reg;

endmodule
`default_nettype wire

FILE: rtl/serial_frame_checker_with_ack_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_checker_with_ack_top
// Length-prefixed frame receiver with CRC-16 check and acknowledge output.
// ----------------------------------------------------------------------------
// A byte that causes no result does not stall the input; the next byte is taken at once.
// A byte that causes an error goes through the ERROR state, then the output register.
// A good frame of length L gives L-5 payload items read from the frame store, then 5
// ACK items, one per cycle unless the output stalls; the first goes through the state
// and output registers after the sync byte, and input stalls until the last ACK item.
// Reset clears framing state and sets the sync byte to 0x7E; the store is not cleared.
module serial_frame_checker_with_ack_top #(
    parameter int MAX_FRAME = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       out_kind,
    output logic [7:0]       out_data,
    output logic [1:0]       error_code,
    output logic             last
);
    import sfc_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);
    localparam int LW = $clog2(MAX_FRAME + 1);

    logic [7:0]     sync_reg;
    mem_ctl_t       mem_ctl;
    logic [AW-1:0]  mem_waddr;
    logic [AW-1:0]  mem_raddr;
    logic [7:0]     mem_wdata;
    logic [7:0]     mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= SYNC_RESET;
        end
        else if (cfg_wr_en)
        begin
            sync_reg <= cfg_wr_data;
        end
    end

    sfc_ctrl #(
        .MAX_FRAME (MAX_FRAME),
        .AW        (AW),
        .LW        (LW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .sync_value (sync_reg),
        .mem_ctl    (mem_ctl),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_kind   (out_kind),
        .out_data   (out_data),
        .error_code (error_code),
        .last       (last)
    );

    sfc_frame_mem #(
        .DEPTH (MAX_FRAME),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire

FILE: rtl/sfc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_checker
// Port-level checks on the frame checker's result stream.
// ----------------------------------------------------------------------------
module sfc_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_stall,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [1:0] out_kind,
    input  wire logic [7:0] out_data,
    input  wire logic [1:0] error_code,
    input  wire logic       last
);
    import sfc_pkg::*;

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(out_kind)
            && $stable(last))
        else $error("stalled result changed");

    // An error result stands alone, carries a code and no data.
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_ERROR) |-> last && (out_data == 8'd0)
            && (error_code != ERR_NONE))
        else $error("malformed error result");

    // Payload and ACK items never carry an error code.
    a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind != KIND_ERROR) |-> (error_code == ERR_NONE))
        else $error("error code on a good result");

    // Results of one frame follow each other with no gap.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside a frame's results");

    // No new byte is taken before a frame's results are all issued.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> in_stall)
        else $error("input taken during result readout");

endmodule

bind serial_frame_checker_with_ack_top sfc_checker u_sfc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_data   (out_data),
    .error_code (error_code),
    .last       (last)
);
`default_nettype wire
